// ===== src/psc_pkg.sv =====
// Shared types, widths and register codes for the PID speed controller.
package psc_pkg;

    localparam int SPEED_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ERR_W      = SPEED_W + 1;
    localparam int INTEG_W    = 8;
    localparam int ACC_W      = ERR_W + 1;
    localparam int DERIV_W    = ERR_W + 1;
    localparam int DUTY_W     = 8;
    localparam int FRAC_W     = 8;

    localparam int PROD_P_W = GAIN_W + ERR_W;
    localparam int PROD_I_W = GAIN_W + INTEG_W;
    localparam int PROD_D_W = GAIN_W + DERIV_W;
    localparam int SUM_W    = PROD_D_W + 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P         = 2'd0,
        REG_GAIN_I         = 2'd1,
        REG_GAIN_D         = 2'd2,
        REG_INTEGRAL_LIMIT = 2'd3
    } psc_reg_idx_t;

    // Terms handed from the error stage to the multiply stage.
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] acc;
        logic signed [DERIV_W-1:0] deriv;
    } psc_terms_t;

endpackage

// ===== src/psc_update.sv =====
// Error stage: forms the error, the clamped integral and the derivative, and holds the loop state.
module psc_update
    import psc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic signed [SPEED_W-1:0] target_speed,
    input  logic signed [SPEED_W-1:0] measured_speed,
    input  logic [LIMIT_W-1:0]        integral_limit,
    output psc_terms_t                terms
);

    logic signed [INTEG_W-1:0] integral_reg;
    logic signed [ERR_W-1:0]   prev_err_reg;
    psc_terms_t                terms_reg;
    psc_terms_t                terms_next;

    logic signed [ERR_W-1:0] err;
    logic signed [ACC_W-1:0] acc_full;
    logic signed [ACC_W-1:0] acc_clamped;
    logic signed [ACC_W-1:0] lim;

    always_comb
    begin
        err      = ERR_W'(target_speed) - ERR_W'(measured_speed);
        acc_full = ACC_W'(integral_reg) + ACC_W'(err);
        lim      = signed'(ACC_W'(integral_limit));
        // The sum is held at full width, so clamping never sees a wrapped value.
        if (acc_full > lim)
        begin
            acc_clamped = lim;
        end
        else if (acc_full < -lim)
        begin
            acc_clamped = -lim;
        end
        else
        begin
            acc_clamped = acc_full;
        end
        terms_next.err   = err;
        terms_next.acc   = INTEG_W'(acc_clamped);
        terms_next.deriv = DERIV_W'(err) - DERIV_W'(prev_err_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            prev_err_reg <= '0;
        end
        else if (load)
        begin
            integral_reg <= terms_next.acc;
            prev_err_reg <= terms_next.err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

// ===== src/pid_speed_controller.sv =====
// Top level of the PID speed controller with integral clamp.
//
// Usage: each input beat carries one control sample (target_speed and
// measured_speed, signed). The block forms the error, accumulates it into an
// integral clamped to plus or minus integral_limit, takes the difference to
// the previous error, and returns Kp*e + Ki*i + Kd*d with signed Q8.8 gains,
// floored by 2^8 and saturated to 0..255 as drive_duty, together with the
// speed_error of that sample. Every input beat gives exactly one output beat.
// An accepted input beat passes the error stage, the multiply stage (three
// independent multipliers) and the sum and saturate stage, each ending in a
// register, before out_valid. Throughput is one beat per cycle unless
// out_stall holds it; the integral and previous-error update keeps pace.
// When out_stall is held, the result stays on the outputs and the pipeline
// keeps filling; in_stall rises only once all three stages hold a beat.
// Gains and the limit must be written through the cfg port only while the
// block is idle, which it does not enforce. Reset clears the pipeline, the
// integral and previous error, zeroes the gains, sets the integral limit to 100.
module pid_speed_controller
    import psc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [SPEED_W-1:0]   target_speed,
    input  logic signed [SPEED_W-1:0]   measured_speed,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [DUTY_W-1:0]           drive_duty,
    output logic signed [ERR_W-1:0]     speed_error
);

    // Configuration registers.
    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;
    logic [LIMIT_W-1:0]       limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (psc_reg_idx_t'(cfg_index))
                REG_GAIN_P:         gain_p_reg <= signed'(GAIN_W'(cfg_data));
                REG_GAIN_I:         gain_i_reg <= signed'(GAIN_W'(cfg_data));
                REG_GAIN_D:         gain_d_reg <= signed'(GAIN_W'(cfg_data));
                REG_INTEGRAL_LIMIT: limit_reg  <= LIMIT_W'(cfg_data);
                default:            ;
            endcase
        end
    end

    // Stage occupancy and the ready chain. A stage moves on when the one after
    // it is empty or moving on itself in the same cycle.
    logic v1_reg, v2_reg, v3_reg;
    logic ready1, ready2, ready3;
    logic in_accept;

    assign ready3    = !v3_reg || !out_stall;
    assign ready2    = !v2_reg || ready3;
    assign ready1    = !v1_reg || ready2;
    assign in_stall  = !ready1;
    assign in_accept = in_valid && ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_accept;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage one: error, clamped integral and derivative; the loop state
    // advances on every accepted beat.
    psc_terms_t terms;

    psc_update u_update
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (in_accept),
        .target_speed   (target_speed),
        .measured_speed (measured_speed),
        .integral_limit (limit_reg),
        .terms          (terms)
    );

    // Stage two: the three products, each registered.
    logic signed [PROD_P_W-1:0] prod_p_reg;
    logic signed [PROD_I_W-1:0] prod_i_reg;
    logic signed [PROD_D_W-1:0] prod_d_reg;
    logic signed [ERR_W-1:0]    err2_reg;
    logic                       load2;

    assign load2 = v1_reg && ready2;

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            prod_p_reg <= PROD_P_W'(gain_p_reg) * PROD_P_W'(terms.err);
            prod_i_reg <= PROD_I_W'(gain_i_reg) * PROD_I_W'(terms.acc);
            prod_d_reg <= PROD_D_W'(gain_d_reg) * PROD_D_W'(terms.deriv);
            err2_reg   <= terms.err;
        end
    end

    // Stage three: sum, floor by 2^8 and saturate to the duty range. The
    // arithmetic shift floors toward minus infinity, so any negative sum ends
    // at zero and any shifted value of 256 or more ends at full duty.
    logic signed [SUM_W-1:0] sum;
    logic [DUTY_W-1:0]       duty_next;
    logic [DUTY_W-1:0]       duty_reg;
    logic signed [ERR_W-1:0] err3_reg;
    logic                    load3;

    assign load3 = v2_reg && ready3;

    always_comb
    begin
        sum = SUM_W'(prod_p_reg) + SUM_W'(prod_i_reg) + SUM_W'(prod_d_reg);
        if (sum[SUM_W-1])
        begin
            duty_next = '0;
        end
        else if (|sum[SUM_W-2:FRAC_W+DUTY_W])
        begin
            duty_next = '1;
        end
        else
        begin
            duty_next = sum[FRAC_W+DUTY_W-1:FRAC_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            duty_reg <= duty_next;
            err3_reg <= err2_reg;
        end
    end

    assign out_valid   = v3_reg;
    assign drive_duty  = duty_reg;
    assign speed_error = err3_reg;

endmodule

// ===== src/psc_checker.sv =====
// Port-level checker for the PID speed controller and its bind.
module psc_checker
    import psc_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [DUTY_W-1:0]         drive_duty,
    input logic signed [ERR_W-1:0]   speed_error
);

    // A stalled result beat stays on the outputs unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive_duty) && $stable(speed_error))
        else $error("psc: stalled output beat changed");

    // The input side only stalls when the output holds a beat that is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || !out_stall |-> !in_stall)
        else $error("psc: input stalled while the output could drain");

    // Once reset has been seen at a clock edge, no result is shown at the next one.
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("psc: output valid during reset");

    // An empty pipeline never presents a stall, so input arriving while idle is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !out_valid |-> !in_stall)
        else $error("psc: input refused with an empty output stage");

endmodule

bind pid_speed_controller psc_checker u_psc_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive_duty     (drive_duty),
    .speed_error    (speed_error)
);

// ===== tb/sv/pid_speed_controller_test.sv =====
// Self-checking testbench for the PID speed controller with integral clamp.
`timescale 1ns / 1ps

module pid_speed_controller_test;
    import psc_pkg::*;

    // The run is cut off here.
    localparam int CYCLE_LIMIT    = 400000;
    // Cycles to let pass once the result stream has gone quiet.
    localparam int SETTLE_CYCLES  = 8;
    // Idling is allowed only in the first part of each window of this many
    // cycles, so that long stretches of back-to-back beats occur as well.
    localparam int IDLE_WINDOW    = 2048;
    localparam int IDLE_OPEN      = 1536;
    localparam int IDLE_PERCENT   = 17;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_SAMPLES  = 244;

    typedef struct packed {
        logic signed [SPEED_W-1:0] target;
        logic signed [SPEED_W-1:0] measured;
    } speed_sample_t;

    typedef struct packed {
        logic [DUTY_W-1:0]       duty;
        logic signed [ERR_W-1:0] err;
    } duty_result_t;

    logic                      clk            = 1'b0;
    logic                      rst_n          = 1'b0;
    logic                      cfg_write      = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index      = '0;
    logic [CFG_DATA_W-1:0]     cfg_data       = '0;
    logic                      in_valid       = 1'b0;
    logic                      in_stall;
    logic signed [SPEED_W-1:0] target_speed   = '0;
    logic signed [SPEED_W-1:0] measured_speed = '0;
    logic                      out_valid;
    logic                      out_stall      = 1'b0;
    logic [DUTY_W-1:0]         drive_duty;
    logic signed [ERR_W-1:0]   speed_error;

    // Samples waiting to be sent, and the duty results they are predicted to give.
    speed_sample_t pending_samples[$];
    duty_result_t  expected_results[$];
    speed_sample_t next_sample;
    duty_result_t  got_result;

    int cycle_count    = 0;
    int mismatch_count = 0;

    // Controller state as the testbench sees it: the gains and clamp as last
    // written, and the integral and previous error after the last accepted beat.
    logic signed [GAIN_W-1:0]  kp_gain;
    logic signed [GAIN_W-1:0]  ki_gain;
    logic signed [GAIN_W-1:0]  kd_gain;
    logic [LIMIT_W-1:0]        clamp_limit;
    logic signed [INTEG_W-1:0] integral_acc;
    logic signed [ERR_W-1:0]   last_error;

    pid_speed_controller dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .target_speed   (target_speed),
        .measured_speed (measured_speed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive_duty     (drive_duty),
        .speed_error    (speed_error)
    );

    always #10 clk = ~clk;

    // One control step. The integral sum is formed at full width before the
    // clamp, so a large error can never wrap it. The weighted sum is exact;
    // the arithmetic shift floors towards minus infinity before saturation.
    function automatic duty_result_t compute_duty(input logic signed [SPEED_W-1:0] tgt,
                                                  input logic signed [SPEED_W-1:0] meas);
        int           err;
        int           acc;
        int           deriv;
        int           lim;
        longint       weighted;
        longint       scaled;
        duty_result_t res;
        err   = int'(tgt) - int'(meas);
        lim   = int'(clamp_limit);
        acc   = int'(integral_acc) + err;
        if (acc > lim)
            acc = lim;
        if (acc < -lim)
            acc = -lim;
        deriv = err - int'(last_error);
        weighted = longint'(kp_gain) * err + longint'(ki_gain) * acc
                 + longint'(kd_gain) * deriv;
        scaled = weighted >>> FRAC_W;
        if (scaled > 255)
            scaled = 255;
        if (scaled < 0)
            scaled = 0;
        integral_acc = INTEG_W'(acc);
        last_error   = ERR_W'(err);
        res.duty = DUTY_W'(scaled);
        res.err  = ERR_W'(err);
        return res;
    endfunction

    // Random idling on either side, shut off in the quiet part of each window.
    function automatic bit idle_now();
        return ((cycle_count % IDLE_WINDOW) < IDLE_OPEN)
            && ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    // Cycle counter and watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("pid_speed_controller_test: FAIL");
            $finish;
        end
    end

    // Sender. A beat that is stalled keeps its payload and its valid; a new
    // beat is offered only once the previous one has gone or none was offered.
    // The prediction is made at the edge where the beat is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(compute_duty(target_speed, measured_speed));
            if (!in_valid || !in_stall)
            begin
                if (pending_samples.size() != 0 && !idle_now())
                begin
                    next_sample    = pending_samples.pop_front();
                    target_speed   <= next_sample.target;
                    measured_speed <= next_sample.measured;
                    in_valid       <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Each result beat taken is checked field by field against the
    // oldest prediction; the stall is then redrawn for the next cycle.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no prediction waiting: drive_duty %0d, speed_error %0d",
                           drive_duty, speed_error);
                    mismatch_count++;
                end
                else
                begin
                    got_result = expected_results.pop_front();
                    if (drive_duty !== got_result.duty)
                    begin
                        $error("drive_duty: expected %0d, actual %0d", got_result.duty, drive_duty);
                        mismatch_count++;
                    end
                    if (speed_error !== got_result.err)
                    begin
                        $error("speed_error: expected %0d, actual %0d",
                               got_result.err, speed_error);
                        mismatch_count++;
                    end
                end
            end
            out_stall <= idle_now();
        end
    end

    // Blocks until every sample has been sent and every result has come back.
    task automatic wait_drained();
        while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // One register write. The caller lowers the write enable.
    task automatic write_reg(input psc_reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_GAIN_P:         kp_gain     = data;
            REG_GAIN_I:         ki_gain     = data;
            REG_GAIN_D:         kd_gain     = data;
            REG_INTEGRAL_LIMIT: clamp_limit = data[LIMIT_W-1:0];
            default:            ;
        endcase
        @(posedge clk);
    endtask

    // Reprograms all four registers once the block has gone idle. The bits
    // above the clamp field are filled at random; the block must ignore them.
    task automatic load_gains(input logic signed [GAIN_W-1:0] p,
                              input logic signed [GAIN_W-1:0] i,
                              input logic signed [GAIN_W-1:0] d,
                              input logic [LIMIT_W-1:0]       lim);
        logic [CFG_DATA_W-1:0] limit_word;
        wait_drained();
        repeat (4) @(posedge clk);
        limit_word = {CFG_DATA_W'($urandom)} << LIMIT_W;
        limit_word[LIMIT_W-1:0] = lim;
        write_reg(REG_GAIN_P, p);
        write_reg(REG_GAIN_I, i);
        write_reg(REG_GAIN_D, d);
        write_reg(REG_INTEGRAL_LIMIT, limit_word);
        cfg_write <= 1'b0;
    endtask

    task automatic add_sample(input int tgt, input int meas);
        speed_sample_t s;
        s.target   = SPEED_W'(tgt);
        s.measured = SPEED_W'(meas);
        pending_samples.push_back(s);
    endtask

    // Mostly gains from -1.0 up to just under 5.0, so the duty lands inside
    // its range; now and then a gain at an extreme or zero.
    function automatic logic signed [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 15))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            default: return GAIN_W'(int'($urandom_range(0, 1535)) - 256);
        endcase
    endfunction

    // Random samples. Most sit close to their setpoint so the loop behaves
    // like a real controller; some have a larger error and a few are noise.
    task automatic add_random_samples(input int count);
        int tgt;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            tgt  = int'($urandom_range(0, 65535)) - 32768;
            pick = $urandom_range(0, 99);
            if (pick < 60)
                add_sample(tgt, tgt - (int'($urandom_range(0, 300)) - 150));
            else if (pick < 85)
                add_sample(tgt, tgt - (int'($urandom_range(0, 8000)) - 4000));
            else
                add_sample(tgt, int'($urandom_range(0, 65535)) - 32768);
        end
    endtask

    initial
    begin
        logic [LIMIT_W-1:0] lim;
        // Registers and state as they come out of reset.
        kp_gain      = '0;
        ki_gain      = '0;
        kd_gain      = '0;
        clamp_limit  = LIMIT_RESET;
        integral_acc = '0;
        last_error   = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // A few beats on the reset settings: every gain is zero, so duty is zero.
        add_sample(1000, 0);
        add_sample(-1000, 0);

        // Unity-ish gains with the default clamp: zero error, errors of one,
        // the largest errors both ways (integral step clamped, duty saturated
        // high and low) and equal extremes on both inputs.
        load_gains(16'sh0100, 16'sh0040, 16'sh0080, 7'd100);
        add_sample(0, 0);
        add_sample(1, 0);
        add_sample(0, 1);
        add_sample(32767, -32768);
        add_sample(-32768, 32767);
        add_sample(32767, 32767);
        add_sample(-32768, -32768);
        add_sample(-32768, 0);
        add_sample(0, -32768);
        add_sample(300, 0);
        add_sample(-3, 0);
        add_sample(40, 41);

        // A clamp of zero holds the integral at zero whatever the error.
        load_gains(16'sh0100, 16'sh0040, 16'sh0080, 7'd0);
        add_sample(50, 0);
        add_sample(-50, 0);
        add_sample(0, 0);

        // Gains at their extremes with the widest clamp.
        load_gains(16'sh8000, 16'sh7fff, 16'sh7fff, 7'd127);
        add_sample(32767, -32768);
        add_sample(-32768, 32767);
        add_sample(1, 0);
        add_sample(0, 0);
        add_sample(-1, 0);

        // Random phases. Every phase boundary holds the sender back until all
        // results are in, then rewrites the registers.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
                lim = '0;
            else if (ph == 1)
                lim = 7'd127;
            else
                lim = LIMIT_W'($urandom_range(0, 127));
            load_gains(pick_gain(), pick_gain(), pick_gain(), lim);
            add_random_samples(PHASE_SAMPLES);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("pid_speed_controller_test: PASS");
        else
            $display("pid_speed_controller_test: FAIL");
        $finish;
    end

endmodule

// ===== pid_speed_controller.f =====
src/psc_pkg.sv
src/psc_update.sv
src/pid_speed_controller.sv
src/psc_checker.sv
tb/sv/pid_speed_controller_test.sv
